// File: sv/ppm_pkg.sv
// ---------------------------------------------------------------------------
// PPM matcher package
// Shared types and constants of the ppm window adduct pair matcher.
// ---------------------------------------------------------------------------
package ppm_pkg;

	localparam int MASS_W      = 28;
	localparam int PPM_W       = 10;
	localparam int RT_W        = 16;
	localparam int ROWS_W      = 11;
	localparam int ROW_W       = 10;
	localparam int ID_W        = 16;
	localparam int TIME_W      = 24;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int MAX_RESULTS = 32;
	localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
	localparam int RIDX_W      = $clog2(MAX_RESULTS);
	localparam int PPM_SCALE   = 1000000;
	localparam int PPM_DEN     = 10 * PPM_SCALE;
	localparam int DEN_W       = $clog2(PPM_DEN + 1);
	localparam int PROD_W      = MASS_W + PPM_W;
	localparam int DPROD_W     = MASS_W + DEN_W;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_SINGLE = 2'd1,
		OP_DOUBLE = 2'd2,
		OP_DRAIN  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PPM  = 2'd0,
		CFG_RT   = 2'd1,
		CFG_ROWS = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CMP_BELOW = 2'd0,
		CMP_IN    = 2'd1,
		CMP_ABOVE = 2'd2
	} cmp_res_t;

	typedef struct packed {
		logic              start;
		logic [MASS_W-1:0] m;
		logic [MASS_W-1:0] x;
		logic [PPM_W-1:0]  ppm;
	} cmp_req_t;

	typedef struct packed {
		logic     done;
		cmp_res_t res;
	} cmp_rsp_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic             sv;
		logic [ID_W-1:0]  sid;
		logic             dv;
		logic [ID_W-1:0]  did;
	} result_t;

endpackage

// File: sv/ppm_if.sv
// ---------------------------------------------------------------------------
// PPM matcher channels
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface ppm_item_if import ppm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic [ROW_W-1:0]  row_index;
	logic [MASS_W-1:0] mass_a;
	logic [MASS_W-1:0] mass_b;
	logic [ID_W-1:0]   sample_id;
	logic [TIME_W-1:0] sample_time;

	modport source (output valid, op, row_index, mass_a, mass_b, sample_id, sample_time,
		input ready);
	modport sink (input valid, op, row_index, mass_a, mass_b, sample_id, sample_time,
		output ready);
endinterface

interface ppm_result_if import ppm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] hit_row;
	logic             single_valid;
	logic [ID_W-1:0]  single_id;
	logic             double_valid;
	logic [ID_W-1:0]  double_id;
	logic             overflow;
	logic             last;

	modport source (output valid, hit_row, single_valid, single_id, double_valid,
		double_id, overflow, last, input ready);
	modport sink (input valid, hit_row, single_valid, single_id, double_valid,
		double_id, overflow, last, output ready);
endinterface

// File: sv/ppm_cmp.sv
// ---------------------------------------------------------------------------
// PPM window compare unit
// Three-stage compare of a sample mass against a row mass with a ppm window.
// ---------------------------------------------------------------------------
module ppm_cmp import ppm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cmp_req_t req,
	output cmp_rsp_t rsp
);

	logic               v_s1, v_s2, v_s3;
	logic [MASS_W-1:0]  d_s1;
	logic [PROD_W-1:0]  p_s1, p_s2;
	logic               up_s1, up_s2;
	logic [DPROD_W-1:0] dd_s2;
	cmp_res_t           res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// x lies above m + tol exactly when (x - m) * DEN > m * ppm, likewise below
	always_ff @(posedge clk) begin
		up_s1 <= req.x > req.m;
		d_s1  <= (req.x > req.m) ? (req.x - req.m) : (req.m - req.x);
		p_s1  <= PROD_W'(req.m) * PROD_W'(req.ppm);
		up_s2 <= up_s1;
		p_s2  <= p_s1;
		dd_s2 <= DPROD_W'(d_s1) * DPROD_W'(PPM_DEN);
		if (dd_s2 <= DPROD_W'(p_s2)) begin
			res_s3 <= CMP_IN;
		end else if (up_s2) begin
			res_s3 <= CMP_ABOVE;
		end else begin
			res_s3 <= CMP_BELOW;
		end
	end

	assign rsp.done = v_s3;
	assign rsp.res  = res_s3;

endmodule

// File: sv/ppm_window_adduct_pair_matcher.sv
// ---------------------------------------------------------------------------
// PPM window adduct pair matcher
// Sorted mass table search with per-row sample slots and pair output.
// ---------------------------------------------------------------------------
// Input items arrive on the item channel and results leave on the result
// channel, both valid/ready. Configuration is a plain write port (cfg_wen,
// cfg_index, cfg_data) to be used only while the block is idle; the block
// itself does not enforce it. A load, or a drain of a row out of range,
// returns to idle. A search sends each probe through the shared three-stage
// compare unit: up to log2(rows)+1 binary-search probes plus one per neighbor
// tried; each window row is then read and, for a single-form sample, given
// a slot if one is free, or for a double-form sample and a drain checked
// slot by slot and written back. Results gather in a 32-entry buffer and
// leave one at a time, each read, loaded into the result register and held
// until taken, with overflow on every result of the item and last on its
// final one. The block takes one item at a time and holds item.ready low
// until its last result is taken; a stall on the result channel holds the
// sequencer. After reset a clearing pass over all TABLE_DEPTH rows empties
// their slot counts and leftover marks; items wait, config writes are taken.
// ---------------------------------------------------------------------------
module ppm_window_adduct_pair_matcher import ppm_pkg::*; #(
	parameter int TABLE_DEPTH   = 1024,
	parameter int SLOTS_PER_ROW = 8,
	parameter int MAX_WINDOW    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ppm_item_if.sink             item,
	ppm_result_if.source         result,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int NW  = $clog2(TABLE_DEPTH + 1);
	localparam int SB  = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
	localparam int CW  = $clog2(SLOTS_PER_ROW + 1);
	localparam int WCW = $clog2(MAX_WINDOW + 1);
	localparam int WIW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int RW  = SLOTS_PER_ROW + CW;
	localparam int SW  = ID_W + TIME_W;
	localparam int SLOT_DEPTH = TABLE_DEPTH << SB;

	typedef enum logic [12:0] {
		S_CLEAR    = 13'b0000000000001,
		S_IDLE     = 13'b0000000000010,
		S_MID      = 13'b0000000000100,
		S_PROBE    = 13'b0000000001000,
		S_PWAIT    = 13'b0000000010000,
		S_CWAIT    = 13'b0000000100000,
		S_ROW_RD   = 13'b0000001000000,
		S_ROW_WT   = 13'b0000010000000,
		S_SLOT_RD  = 13'b0000100000000,
		S_SLOT_CK  = 13'b0001000000000,
		S_ROW_WB   = 13'b0010000000000,
		S_FIN      = 13'b0100000000000,
		S_OUT_RD   = 13'b1000000000000
	} state_t;

	typedef enum logic [1:0] {
		PH_BIN   = 2'd0,
		PH_LEFT  = 2'd1,
		PH_RIGHT = 2'd2
	} phase_t;

	// memories
	logic [2*MASS_W-1:0] mass_mem [TABLE_DEPTH];
	logic [RW-1:0]       row_mem  [TABLE_DEPTH];
	logic [SW-1:0]       slot_mem [SLOT_DEPTH];
	logic [$bits(result_t)-1:0] rbuf [MAX_RESULTS];

	logic [2*MASS_W-1:0] mass_rd_q;
	logic [RW-1:0]       row_rd_q;
	logic [SW-1:0]       slot_rd_q;
	result_t             buf_rd_q;

	// configuration
	logic [PPM_W-1:0]  ppm_q;
	logic [RT_W-1:0]   rt_q;
	logic [ROWS_W-1:0] rows_q;

	// sequencer
	state_t            state_q;
	phase_t            phase_q;
	logic              out_wait_q;
	logic [AW-1:0]     clr_q;
	op_t               op_q;
	logic [ROW_W-1:0]  ri_q;
	logic [MASS_W-1:0] ma_q;
	logic [ID_W-1:0]   sid_q;
	logic [TIME_W-1:0] st_q;
	logic [NW-1:0]     lo_q, rend_q, pa_q, hit_q;
	logic [AW-1:0]     win_q [MAX_WINDOW];
	logic [WCW-1:0]    cnt_q, wi_q;
	logic [CW-1:0]     c_q, k_q;
	logic [SLOTS_PER_ROW-1:0] lft_q;
	logic              paired_q;
	logic              ovf_q;
	logic [RCNT_W-1:0] rcnt_q, oi_q;

	// result register
	logic              out_valid_q;
	result_t           out_q;
	logic              out_ovf_q;
	logic              out_last_q;

	cmp_req_t cmp_req;
	cmp_rsp_t cmp_rsp;

	ppm_cmp u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cmp_req),
		.rsp    (cmp_rsp)
	);

	logic              in_acc;
	logic              ri_ok;
	logic [NW-1:0]     n_rows;
	logic [NW:0]       mid_sum;
	logic [NW:0]       right_from;
	logic [AW-1:0]     cur_row;
	logic [CW-1:0]     c_v;
	logic [SLOTS_PER_ROW-1:0] lft_v, lft_set;
	logic [ID_W-1:0]   slot_s;
	logic [TIME_W-1:0] slot_t, tdiff;
	logic              t_close;
	logic              last_row;

	logic              emit_en;
	result_t           emit_d;
	logic              ovf_set;
	logic              mass_we, row_we, slot_we;
	logic [AW-1:0]     row_waddr;
	logic [RW-1:0]     row_wdata;

	assign in_acc  = item.valid && item.ready;
	assign ri_ok   = 32'(item.row_index) < TABLE_DEPTH;
	assign n_rows  = (32'(rows_q) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(rows_q);
	assign mid_sum = {1'b0, lo_q} + {1'b0, rend_q} - (NW+1)'(1);
	// right expansion starts next to the hit and then walks on from the last probe
	assign right_from = {1'b0, ((phase_q == PH_LEFT) ? hit_q : pa_q)} + (NW+1)'(1);
	assign cur_row = (op_q == OP_DRAIN) ? AW'(ri_q) : win_q[wi_q[WIW-1:0]];
	assign c_v     = row_rd_q[CW-1:0];
	assign lft_v   = row_rd_q[RW-1:CW];
	assign slot_s  = slot_rd_q[SW-1:TIME_W];
	assign slot_t  = slot_rd_q[TIME_W-1:0];
	assign tdiff   = (slot_t > st_q) ? (slot_t - st_q) : (st_q - slot_t);
	assign t_close = tdiff <= TIME_W'(rt_q);
	assign last_row = (wi_q + WCW'(1)) >= cnt_q;

	assign cmp_req.start = (state_q == S_PWAIT);
	assign cmp_req.m     = (op_q == OP_DOUBLE) ? mass_rd_q[MASS_W-1:0]
		: mass_rd_q[2*MASS_W-1:MASS_W];
	assign cmp_req.x     = ma_q;
	assign cmp_req.ppm   = ppm_q;

	always_comb begin
		lft_set = lft_v;
		lft_set[c_v[SB-1:0]] = 1'b1;
	end

	always_comb begin
		emit_en   = 1'b0;
		emit_d    = '0;
		ovf_set   = 1'b0;
		mass_we   = 1'b0;
		row_we    = 1'b0;
		slot_we   = 1'b0;
		row_waddr = cur_row;
		row_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				row_we    = 1'b1;
				row_waddr = clr_q;
			end
			S_IDLE: begin
				mass_we = in_acc && (item.op == OP_LOAD) && ri_ok;
			end
			S_CWAIT: begin
				// further matching neighbour beyond a full window
				if (cmp_rsp.done && (phase_q != PH_BIN) && (cmp_rsp.res == CMP_IN)
						&& (32'(cnt_q) >= MAX_WINDOW)) begin
					ovf_set = 1'b1;
				end
			end
			S_ROW_WT: begin
				if (op_q == OP_SINGLE) begin
					if (32'(c_v) >= SLOTS_PER_ROW) begin
						ovf_set = 1'b1;
					end else begin
						slot_we   = 1'b1;
						row_we    = 1'b1;
						row_wdata = {lft_set, c_v + CW'(1)};
					end
				end
			end
			S_SLOT_CK: begin
				if (op_q == OP_DOUBLE && t_close) begin
					emit_en = 1'b1;
					emit_d  = '{row: ROW_W'(cur_row), sv: 1'b1, sid: slot_s,
						dv: 1'b1, did: sid_q};
				end else if (op_q == OP_DRAIN && lft_q[k_q[SB-1:0]]) begin
					emit_en = 1'b1;
					emit_d  = '{row: ROW_W'(cur_row), sv: 1'b1, sid: slot_s,
						dv: 1'b0, did: '0};
				end
			end
			S_ROW_WB: begin
				row_we = 1'b1;
				if (op_q == OP_DOUBLE) begin
					row_wdata = {lft_q, c_q};
					if (!paired_q) begin
						emit_en = 1'b1;
						emit_d  = '{row: ROW_W'(cur_row), sv: 1'b0, sid: '0,
							dv: 1'b1, did: sid_q};
					end
				end
			end
			S_FIN: begin
				if (op_q == OP_SINGLE && ovf_q && cnt_q != '0) begin
					emit_en = 1'b1;
					emit_d  = '{row: ROW_W'(win_q[0]), sv: 1'b0, sid: '0,
						dv: 1'b0, did: '0};
				end
			end
			default: begin
			end
		endcase
		if (emit_en && rcnt_q >= RCNT_W'(MAX_RESULTS)) begin
			ovf_set = 1'b1;
		end
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (mass_we) begin
			mass_mem[AW'(item.row_index)] <= {item.mass_a, item.mass_b};
		end
		mass_rd_q <= mass_mem[pa_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_waddr] <= row_wdata;
		end
		row_rd_q <= row_mem[cur_row];
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[{cur_row, c_v[SB-1:0]}] <= {sid_q, st_q};
		end
		slot_rd_q <= slot_mem[{cur_row, k_q[SB-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (emit_en && rcnt_q < RCNT_W'(MAX_RESULTS)) begin
			rbuf[rcnt_q[RIDX_W-1:0]] <= emit_d;
		end
		buf_rd_q <= rbuf[oi_q[RIDX_W-1:0]];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppm_q  <= PPM_W'(50);
			rt_q   <= RT_W'(600);
			rows_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_PPM:  ppm_q  <= cfg_data[PPM_W-1:0];
				CFG_RT:   rt_q   <= cfg_data[RT_W-1:0];
				CFG_ROWS: rows_q <= cfg_data[ROWS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			phase_q     <= PH_BIN;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			out_wait_q  <= 1'b0;
			ovf_q       <= 1'b0;
			rcnt_q      <= '0;
			oi_q        <= '0;
			cnt_q       <= '0;
			wi_q        <= '0;
			op_q        <= OP_LOAD;
		end else begin
			if (ovf_set) begin
				ovf_q <= 1'b1;
			end
			if (emit_en && rcnt_q < RCNT_W'(MAX_RESULTS)) begin
				rcnt_q <= rcnt_q + RCNT_W'(1);
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						op_q   <= op_t'(item.op);
						ri_q   <= item.row_index;
						ma_q   <= item.mass_a;
						sid_q  <= item.sample_id;
						st_q   <= item.sample_time;
						ovf_q  <= 1'b0;
						rcnt_q <= '0;
						oi_q   <= '0;
						cnt_q  <= '0;
						wi_q   <= '0;
						lo_q   <= '0;
						rend_q <= n_rows;
						unique case (op_t'(item.op))
							OP_SINGLE, OP_DOUBLE: state_q <= S_MID;
							OP_DRAIN: state_q <= ri_ok ? S_ROW_RD : S_IDLE;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_MID: begin
					if (lo_q < rend_q) begin
						pa_q    <= mid_sum[NW:1];
						phase_q <= PH_BIN;
						state_q <= S_PROBE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_PROBE: state_q <= S_PWAIT;
				S_PWAIT: state_q <= S_CWAIT;
				S_CWAIT: begin
					if (cmp_rsp.done) begin
						if (phase_q == PH_BIN && cmp_rsp.res != CMP_IN) begin
							// narrow the search range
							if (cmp_rsp.res == CMP_ABOVE) begin
								lo_q <= pa_q + NW'(1);
							end else begin
								rend_q <= pa_q;
							end
							state_q <= S_MID;
						end else if (cmp_rsp.res == CMP_IN
								&& (phase_q == PH_BIN || 32'(cnt_q) < MAX_WINDOW)) begin
							win_q[cnt_q[WIW-1:0]] <= pa_q[AW-1:0];
							cnt_q <= cnt_q + WCW'(1);
							if (phase_q == PH_BIN) begin
								hit_q <= pa_q;
							end
							if (phase_q != PH_RIGHT && pa_q != '0) begin
								pa_q    <= pa_q - NW'(1);
								phase_q <= PH_LEFT;
								state_q <= S_PROBE;
							end else if (right_from < {1'b0, n_rows}) begin
								pa_q    <= right_from[NW-1:0];
								phase_q <= PH_RIGHT;
								state_q <= S_PROBE;
							end else begin
								state_q <= S_ROW_RD;
							end
						end else if (phase_q == PH_LEFT
								&& right_from < {1'b0, n_rows}) begin
							// left side done, expand right of the hit
							pa_q    <= right_from[NW-1:0];
							phase_q <= PH_RIGHT;
							state_q <= S_PROBE;
						end else begin
							state_q <= S_ROW_RD;
						end
					end
				end
				S_ROW_RD: state_q <= S_ROW_WT;
				S_ROW_WT: begin
					c_q      <= c_v;
					lft_q    <= lft_v;
					k_q      <= '0;
					paired_q <= 1'b0;
					if (op_q == OP_SINGLE) begin
						if (last_row) begin
							state_q <= S_FIN;
						end else begin
							wi_q    <= wi_q + WCW'(1);
							state_q <= S_ROW_RD;
						end
					end else begin
						state_q <= (c_v == '0) ? S_ROW_WB : S_SLOT_RD;
					end
				end
				S_SLOT_RD: state_q <= S_SLOT_CK;
				S_SLOT_CK: begin
					if (op_q == OP_DOUBLE && t_close) begin
						lft_q[k_q[SB-1:0]] <= 1'b0;
						paired_q <= 1'b1;
					end
					k_q <= k_q + CW'(1);
					state_q <= ((k_q + CW'(1)) < c_q) ? S_SLOT_RD : S_ROW_WB;
				end
				S_ROW_WB: begin
					if (op_q == OP_DOUBLE && !last_row) begin
						wi_q    <= wi_q + WCW'(1);
						state_q <= S_ROW_RD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_OUT_RD;
				S_OUT_RD: begin
					// one buffer read, one load, then hold until taken
					if (out_valid_q) begin
						if (result.ready) begin
							out_valid_q <= 1'b0;
							oi_q        <= oi_q + RCNT_W'(1);
						end
					end else if (out_wait_q) begin
						out_q       <= buf_rd_q;
						out_ovf_q   <= ovf_q;
						out_last_q  <= (oi_q + RCNT_W'(1)) == rcnt_q;
						out_valid_q <= 1'b1;
						out_wait_q  <= 1'b0;
					end else if (oi_q >= rcnt_q) begin
						state_q <= S_IDLE;
					end else begin
						out_wait_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item.ready          = (state_q == S_IDLE);
	assign result.valid        = out_valid_q;
	assign result.hit_row      = out_q.row;
	assign result.single_valid = out_q.sv;
	assign result.single_id    = out_q.sid;
	assign result.double_valid = out_q.dv;
	assign result.double_id    = out_q.did;
	assign result.overflow     = out_ovf_q;
	assign result.last         = out_last_q;

endmodule

// File: sv/ppm_chk.sv
// ---------------------------------------------------------------------------
// PPM matcher port checker
// Concurrent checks on the top-level ports, bound to the matcher.
// ---------------------------------------------------------------------------
module ppm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        single_valid,
	input logic [15:0] single_id,
	input logic        double_valid,
	input logic [15:0] double_id,
	input logic        overflow,
	input logic        last
);

	// hold a result request until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped before taken");

	// no new item while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("item accepted while a result is pending");

	a_single_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !single_valid |-> single_id == 16'd0)
		else $error("single id without single valid");

	a_double_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !double_valid |-> double_id == 16'd0)
		else $error("double id without double valid");

	// an empty result only reports dropped matches
	a_empty_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !single_valid && !double_valid |-> overflow && last)
		else $error("empty result without overflow");

endmodule

bind ppm_window_adduct_pair_matcher ppm_chk u_ppm_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item.valid),
	.in_ready     (item.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.single_valid (result.single_valid),
	.single_id    (result.single_id),
	.double_valid (result.double_valid),
	.double_id    (result.double_id),
	.overflow     (result.overflow),
	.last         (result.last)
);

// File: bench/ppm_window_adduct_pair_matcher_tb.sv
// ---------------------------------------------------------------------------
// PPM window adduct pair matcher testbench
// Loads sorted mass tables, sends single-form, double-form, load and drain
// requests under several tolerance settings and handshake idling patterns,
// and checks every result against an in-bench model of the matcher.
// ---------------------------------------------------------------------------
module ppm_window_adduct_pair_matcher_tb;
	import ppm_pkg::*;

	localparam int DEPTH      = 1024;
	localparam int SLOTS      = 8;
	localparam int WINDOW     = 4;
	localparam int SETTLE     = 400;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [MASS_W-1:0] MASS_MAX = '1;

	typedef struct {
		logic [ROW_W-1:0] row;
		logic             sv;
		logic [ID_W-1:0]  sid;
		logic             dv;
		logic [ID_W-1:0]  did;
		logic             ovf;
		logic             last;
	} match_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	ppm_item_if   item_ch();
	ppm_result_if res_ch();

	ppm_window_adduct_pair_matcher uut (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(res_ch),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// matcher model state
	logic [MASS_W-1:0] single_tab [DEPTH];
	logic [MASS_W-1:0] double_tab [DEPTH];
	logic [ID_W-1:0]   slot_id    [DEPTH*SLOTS];
	logic [TIME_W-1:0] slot_rt    [DEPTH*SLOTS];
	bit                slot_open  [DEPTH*SLOTS];
	int                slot_cnt   [DEPTH];
	logic [PPM_W-1:0]  ppm_set;
	logic [RT_W-1:0]   rt_set;
	logic [ROWS_W-1:0] rows_set;
	int                win_rows [WINDOW];
	bit                win_ovf;
	match_t            item_res [$];
	match_t            match_q  [$];

	int send_idle, recv_stall;
	int errors, n_items, n_results, idle_cycles;

	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	function automatic cmp_res_t mass_cmp(logic [MASS_W-1:0] m, logic [MASS_W-1:0] x);
		logic [63:0] tol;
		tol = (64'(m) * 64'(ppm_set)) / 64'(PPM_DEN);
		if (64'(x) > 64'(m) + tol) return CMP_ABOVE;
		if (64'(x) < 64'(m) - tol) return CMP_BELOW;
		return CMP_IN;
	endfunction

	function automatic logic [MASS_W-1:0] column(bit dbl, int i);
		return dbl ? double_tab[i] : single_tab[i];
	endfunction

	// binary search, then widen left and right while neighbours still match
	function automatic int search_window(bit dbl, logic [MASS_W-1:0] x);
		int n, lo_i, hi_i, mid, cnt, l, r;
		n = rows_set > DEPTH ? DEPTH : int'(rows_set);
		lo_i = 0;
		hi_i = n - 1;
		cnt = 0;
		while (lo_i <= hi_i) begin
			mid = (lo_i + hi_i) / 2;
			case (mass_cmp(column(dbl, mid), x))
				CMP_IN: begin
					win_rows[cnt] = mid;
					cnt++;
					l = mid - 1;
					while (l >= 0 && mass_cmp(column(dbl, l), x) == CMP_IN) begin
						if (cnt >= WINDOW) begin
							win_ovf = 1;
							break;
						end
						win_rows[cnt] = l;
						cnt++;
						l--;
					end
					r = mid + 1;
					while (r < n && mass_cmp(column(dbl, r), x) == CMP_IN) begin
						if (cnt >= WINDOW) begin
							win_ovf = 1;
							break;
						end
						win_rows[cnt] = r;
						cnt++;
						r++;
					end
					return cnt;
				end
				CMP_ABOVE: lo_i = mid + 1;
				default: hi_i = mid - 1;
			endcase
		end
		return 0;
	endfunction

	function automatic void add_result(int row, bit sv, logic [ID_W-1:0] sid, bit dv,
		logic [ID_W-1:0] did);
		match_t m;
		if (item_res.size() >= MAX_RESULTS) begin
			win_ovf = 1;
			return;
		end
		m.row = ROW_W'(row);
		m.sv = sv;
		m.sid = sid;
		m.dv = dv;
		m.did = did;
		m.ovf = 0;
		m.last = 0;
		item_res.push_back(m);
	endfunction

	function automatic void predict_matches(op_t op, logic [ROW_W-1:0] ri,
		logic [MASS_W-1:0] ma, logic [MASS_W-1:0] mb, logic [ID_W-1:0] sid,
		logic [TIME_W-1:0] st);
		int w, r, s;
		bit paired;
		logic [TIME_W-1:0] d;
		win_ovf = 0;
		item_res.delete();
		case (op)
			OP_LOAD: begin
				single_tab[ri] = ma;
				double_tab[ri] = mb;
			end
			OP_SINGLE: begin
				w = search_window(0, ma);
				for (int i = 0; i < w; i++) begin
					r = win_rows[i];
					if (slot_cnt[r] >= SLOTS) begin
						win_ovf = 1;
						continue;
					end
					s = r * SLOTS + slot_cnt[r];
					slot_id[s] = sid;
					slot_rt[s] = st;
					slot_open[s] = 1;
					slot_cnt[r]++;
				end
				if (win_ovf && w > 0) add_result(win_rows[0], 0, '0, 0, '0);
			end
			OP_DOUBLE: begin
				w = search_window(1, ma);
				for (int i = 0; i < w; i++) begin
					r = win_rows[i];
					paired = 0;
					for (int k = 0; k < slot_cnt[r]; k++) begin
						s = r * SLOTS + k;
						d = slot_rt[s] > st ? slot_rt[s] - st : st - slot_rt[s];
						if (d <= TIME_W'(rt_set)) begin
							paired = 1;
							add_result(r, 1, slot_id[s], 1, sid);
							slot_open[s] = 0;
						end
					end
					if (!paired) add_result(r, 0, '0, 1, sid);
				end
			end
			default: begin
				for (int k = 0; k < slot_cnt[ri]; k++)
					if (slot_open[ri*SLOTS + k])
						add_result(ri, 1, slot_id[ri*SLOTS + k], 0, '0);
				for (int k = 0; k < SLOTS; k++) slot_open[ri*SLOTS + k] = 0;
				slot_cnt[ri] = 0;
			end
		endcase
		foreach (item_res[i]) begin
			item_res[i].ovf = win_ovf;
			item_res[i].last = (i == item_res.size() - 1);
			match_q.push_back(item_res[i]);
		end
	endfunction

	task automatic send_request(op_t op, logic [ROW_W-1:0] ri, logic [MASS_W-1:0] ma,
		logic [MASS_W-1:0] mb, logic [ID_W-1:0] sid, logic [TIME_W-1:0] st);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			item_ch.valid = 0;
			@(negedge clk);
		end
		item_ch.valid = 1;
		item_ch.op = op;
		item_ch.row_index = ri;
		item_ch.mass_a = ma;
		item_ch.mass_b = mb;
		item_ch.sample_id = sid;
		item_ch.sample_time = st;
		do @(posedge clk); while (!item_ch.ready);
		predict_matches(op, ri, ma, mb, sid, st);
		n_items++;
	endtask

	// hold the sender until every result is in, then let the block finish
	task automatic settle();
		@(negedge clk);
		item_ch.valid = 0;
		while (match_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		item_ch.valid = 0;
		cfg_wen = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wen = 0;
		case (idx)
			CFG_PPM: ppm_set = val[PPM_W-1:0];
			CFG_RT: rt_set = val[RT_W-1:0];
			default: rows_set = val[ROWS_W-1:0];
		endcase
	endtask

	always @(negedge clk)
		res_ch.ready = ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		match_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			n_results++;
			if (match_q.size() == 0) begin
				$display("%0t: unexpected result row=%0d", $time, res_ch.hit_row);
				errors++;
			end else begin
				e = match_q.pop_front();
				if (res_ch.hit_row !== e.row || res_ch.single_valid !== e.sv ||
					res_ch.single_id !== e.sid || res_ch.double_valid !== e.dv ||
					res_ch.double_id !== e.did || res_ch.overflow !== e.ovf ||
					res_ch.last !== e.last) begin
					$display("%0t: mismatch expected row=%0d sv=%b sid=%h dv=%b did=%h ovf=%b last=%b",
						$time, e.row, e.sv, e.sid, e.dv, e.did, e.ovf, e.last);
					$display("%0t:          actual row=%0d sv=%b sid=%h dv=%b did=%h ovf=%b last=%b",
						$time, res_ch.hit_row, res_ch.single_valid, res_ch.single_id,
						res_ch.double_valid, res_ch.double_id, res_ch.overflow, res_ch.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [MASS_W-1:0] near_mass(logic [MASS_W-1:0] m);
		longint tol, x;
		tol = (longint'(m) * longint'(ppm_set)) / longint'(PPM_DEN);
		if ($urandom_range(1)) return m;
		x = longint'(m) + longint'($urandom_range(4*tol + 4)) - 2*tol - 2;
		if (x < 0) x = 0;
		if (x > longint'(MASS_MAX)) x = MASS_MAX;
		return MASS_W'(x);
	endfunction

	task automatic load_table(int n);
		longint m, tol;
		m = $urandom_range(200000000);
		for (int i = 0; i < n; i++) begin
			tol = (m * longint'(ppm_set)) / longint'(PPM_DEN);
			m += $urandom_range(3*tol + 3);
			send_request(OP_LOAD, ROW_W'(i), MASS_W'(m), MASS_W'(m / 2), ID_W'($urandom),
				TIME_W'($urandom));
		end
		write_reg(CFG_ROWS, CFG_W'(n));
	endtask

	task automatic test_empty_table();
		send_request(OP_SINGLE, '0, 28'd1000, '0, 16'h1234, 24'd50);
		send_request(OP_DOUBLE, '1, 28'd500, '1, 16'h4321, 24'd50);
		send_request(OP_DRAIN, 10'd5, '0, '0, '0, '0);
		settle();
		// saturating row count, then back to empty before any search
		write_reg(CFG_ROWS, 16'd2047);
		write_reg(CFG_ROWS, 16'd0);
	endtask

	task automatic test_directed_table();
		logic [MASS_W-1:0] m;
		write_reg(CFG_PPM, 16'd50);
		write_reg(CFG_RT, 16'd600);
		for (int i = 0; i < 10; i++) begin
			m = (i == 0) ? '0 : (i <= 6) ? MASS_W'(50000000 + 100*i) :
				(i == 7) ? 28'd100000000 : (i == 8) ? 28'd150000000 : MASS_MAX;
			send_request(OP_LOAD, ROW_W'(i), m, (i == 9) ? MASS_MAX : m / 2, '0, '0);
		end
		write_reg(CFG_ROWS, 16'd10);
		send_request(OP_SINGLE, '0, 28'd100000000, '0, 16'h0000, 24'd0);
		// pair at the edge of the time window, then a lone double-form result
		send_request(OP_DOUBLE, '0, 28'd50000000, '0, 16'hFFFF, 24'd600);
		send_request(OP_DOUBLE, '0, 28'd50000000, '0, 16'h00A5, 24'd1000);
		// cluster wider than the window
		send_request(OP_SINGLE, '0, 28'd50000300, '0, 16'h0001, 24'hFFFFFF);
		send_request(OP_DOUBLE, '0, 28'd25000150, '0, 16'h0002, 24'hFFFDA9);
		send_request(OP_SINGLE, '0, 28'd0, '0, 16'h0003, 24'd7);
		send_request(OP_SINGLE, '0, MASS_MAX, '0, 16'hFFFF, 24'd9);
		send_request(OP_DRAIN, 10'd9, '0, '0, '0, '0);
		send_request(OP_DRAIN, 10'd9, '0, '0, '0, '0);
		// fill every slot of one row, then one more
		for (int i = 0; i < SLOTS + 1; i++)
			send_request(OP_SINGLE, '0, 28'd150000000, '0, ID_W'(16'h100 + i), 24'(i));
		send_request(OP_DRAIN, 10'd8, '0, '0, '0, '0);
		send_request(OP_DRAIN, 10'd0, '0, '0, '0, '0);
		send_request(OP_DRAIN, 10'd7, '0, '0, '0, '0);
		settle();
	endtask

	task automatic random_traffic(int count, int n);
		int r, sel;
		longint t, span;
		logic [TIME_W-1:0] base_t;
		base_t = TIME_W'($urandom);
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(n - 1);
			sel = $urandom_range(99);
			span = 2 * longint'(rt_set) + 10;
			t = longint'(base_t) + longint'($urandom_range(2*span)) - span;
			if (t < 0 || t > 64'hFFFFFF || $urandom_range(9) == 0) t = $urandom;
			if (sel < 40)
				send_request(OP_SINGLE, ROW_W'($urandom), near_mass(single_tab[r]),
					MASS_W'($urandom), ID_W'($urandom), TIME_W'(t));
			else if (sel < 75)
				send_request(OP_DOUBLE, ROW_W'($urandom), near_mass(double_tab[r]),
					MASS_W'($urandom), ID_W'($urandom), TIME_W'(t));
			else if (sel < 87)
				send_request(OP_DRAIN, $urandom_range(1) ? ROW_W'(r) : ROW_W'($urandom),
					MASS_W'($urandom), MASS_W'($urandom), ID_W'($urandom),
					TIME_W'($urandom));
			else if (sel < 92)
				send_request(OP_LOAD, ROW_W'($urandom), MASS_W'($urandom),
					MASS_W'($urandom), ID_W'($urandom), TIME_W'($urandom));
			else
				send_request($urandom_range(1) ? OP_SINGLE : OP_DOUBLE, ROW_W'($urandom),
					MASS_W'($urandom), MASS_W'($urandom), ID_W'($urandom),
					TIME_W'($urandom));
		end
	endtask

	task automatic test_random_phases();
		int n;
		for (int p = 0; p < 4; p++) begin
			send_idle = (p == 1) ? 47 : (p == 3) ? 18 : 0;
			recv_stall = (p == 2) ? 47 : (p == 3) ? 18 : 0;
			case (p)
				0: begin write_reg(CFG_PPM, 16'd1000); write_reg(CFG_RT, 16'hFFFF); end
				1: begin write_reg(CFG_PPM, 16'd0); write_reg(CFG_RT, 16'd0); end
				2: begin write_reg(CFG_PPM, 16'd50); write_reg(CFG_RT, 16'd600); end
				default: begin
					write_reg(CFG_PPM, CFG_W'($urandom_range(1000)));
					write_reg(CFG_RT, CFG_W'($urandom));
				end
			endcase
			n = $urandom_range(4, 20);
			load_table(n);
			random_traffic(50, n);
			settle();
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_wen = 0;
		cfg_index = CFG_PPM;
		cfg_data = '0;
		item_ch.valid = 0;
		item_ch.op = OP_LOAD;
		item_ch.row_index = '0;
		item_ch.mass_a = '0;
		item_ch.mass_b = '0;
		item_ch.sample_id = '0;
		item_ch.sample_time = '0;
		res_ch.ready = 0;
		send_idle = 0;
		recv_stall = 0;
		errors = 0;
		n_items = 0;
		n_results = 0;
		idle_cycles = 0;
		ppm_set = 10'd50;
		rt_set = 16'd600;
		rows_set = '0;
		foreach (slot_cnt[i]) slot_cnt[i] = 0;
		foreach (slot_open[i]) slot_open[i] = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_empty_table();
		test_directed_table();
		test_random_phases();
		settle();

		$display("Sent %0d requests and checked %0d results over four idling patterns,",
			n_items, n_results);
		$display("with tolerance extremes, window and slot overflow, pairing and drains.");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
